FILE: rtl/core/gtr_pkg.sv
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared types, constants and the 5x8 font for the glyph text rasterizer.
// ----------------------------------------------------------------------------
package gtr_pkg;

    localparam int FIELD_BITS  = 16;
    localparam int GLYPH_BITS  = 40;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CODE_LOW  = 8'd32;
    localparam logic [7:0] CODE_HIGH = 8'd126;
    localparam logic [2:0] CELL_STEP = 3'd6;
    localparam logic [2:0] LAST_COL  = 3'd4;
    localparam logic [2:0] LAST_ROW  = 3'd7;

    // One drawable character as handed from the front to the back.
    typedef struct packed {
        logic [GLYPH_BITS-1:0] glyph;   // column c in bits [8c+7:8c], row r at bit r
        logic [FIELD_BITS-1:0] bg;
        logic [FIELD_BITS-1:0] fg;
        logic [FIELD_BITS-1:0] pos_y;
        logic [FIELD_BITS-1:0] cell_x;
    } cmd_t;

    // Font: index is code minus 32; result is {col4, col3, col2, col1, col0}.
    function automatic logic [GLYPH_BITS-1:0] glyph_cols(input logic [6:0] idx);
        logic [GLYPH_BITS-1:0] g;
        unique case (idx)
            7'd0:  g = 40'h0000000000;
            7'd1:  g = 40'h00005F0000;
            7'd2:  g = 40'h0007000700;
            7'd3:  g = 40'h147F147F14;
            7'd4:  g = 40'h122A7F2A24;
            7'd5:  g = 40'h6264081323;
            7'd6:  g = 40'h5022554936;
            7'd7:  g = 40'h0000030500;
            7'd8:  g = 40'h0041221C00;
            7'd9:  g = 40'h001C224100;
            7'd10: g = 40'h14083E0814;
            7'd11: g = 40'h08083E0808;
            7'd12: g = 40'h0000305000;
            7'd13: g = 40'h0808080808;
            7'd14: g = 40'h0000606000;
            7'd15: g = 40'h0204081020;
            7'd16: g = 40'h3E4549513E;
            7'd17: g = 40'h00407F4200;
            7'd18: g = 40'h4649516142;
            7'd19: g = 40'h314B454121;
            7'd20: g = 40'h107F121418;
            7'd21: g = 40'h3945454527;
            7'd22: g = 40'h3049494A3C;
            7'd23: g = 40'h0305097101;
            7'd24: g = 40'h3649494936;
            7'd25: g = 40'h1E29494906;
            7'd26: g = 40'h0000363600;
            7'd27: g = 40'h0000365600;
            7'd28: g = 40'h0041221408;
            7'd29: g = 40'h1414141414;
            7'd30: g = 40'h0814224100;
            7'd31: g = 40'h0609510102;
            7'd32: g = 40'h3E41794932;
            7'd33: g = 40'h7E1111117E;
            7'd34: g = 40'h364949497F;
            7'd35: g = 40'h224141413E;
            7'd36: g = 40'h1C2241417F;
            7'd37: g = 40'h414949497F;
            7'd38: g = 40'h010909097F;
            7'd39: g = 40'h7A4949413E;
            7'd40: g = 40'h7F0808087F;
            7'd41: g = 40'h00417F4100;
            7'd42: g = 40'h013F414020;
            7'd43: g = 40'h412214087F;
            7'd44: g = 40'h404040407F;
            7'd45: g = 40'h7F0204027F;
            7'd46: g = 40'h7F1008047F;
            7'd47: g = 40'h3E4141413E;
            7'd48: g = 40'h060909097F;
            7'd49: g = 40'h5E2151413E;
            7'd50: g = 40'h462919097F;
            7'd51: g = 40'h3149494946;
            7'd52: g = 40'h01017F0101;
            7'd53: g = 40'h3F4040403F;
            7'd54: g = 40'h1F2040201F;
            7'd55: g = 40'h7F2018207F;
            7'd56: g = 40'h6314081463;
            7'd57: g = 40'h0708700807;
            7'd58: g = 40'h4345495161;
            7'd59: g = 40'h0041417F00;
            7'd60: g = 40'h2010080402;
            7'd61: g = 40'h007F414100;
            7'd62: g = 40'h0402010204;
            7'd63: g = 40'h8080808080;
            7'd64: g = 40'h0000070300;
            7'd65: g = 40'h7854545420;
            7'd66: g = 40'h384444487F;
            7'd67: g = 40'h2044444438;
            7'd68: g = 40'h7F48444438;
            7'd69: g = 40'h1854545438;
            7'd70: g = 40'h0201097E08;
            7'd71: g = 40'h3E5252520C;
            7'd72: g = 40'h780404087F;
            7'd73: g = 40'h00407D4400;
            7'd74: g = 40'h003D444020;
            7'd75: g = 40'h004428107F;
            7'd76: g = 40'h00407F4100;
            7'd77: g = 40'h780418047C;
            7'd78: g = 40'h780404087C;
            7'd79: g = 40'h3844444438;
            7'd80: g = 40'h081414147C;
            7'd81: g = 40'h7C18141408;
            7'd82: g = 40'h080404087C;
            7'd83: g = 40'h2054545448;
            7'd84: g = 40'h2040443F04;
            7'd85: g = 40'h7C2040403C;
            7'd86: g = 40'h1C2040201C;
            7'd87: g = 40'h3C4030403C;
            7'd88: g = 40'h4428102844;
            7'd89: g = 40'h3C5050500C;
            7'd90: g = 40'h444C546444;
            7'd91: g = 40'h0041360800;
            7'd92: g = 40'h00007F0000;
            7'd93: g = 40'h0008364100;
            7'd94: g = 40'h0810080810;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

FILE: rtl/core/glyph_text_rasterizer_core.sv
// ----------------------------------------------------------------------------
// glyph_text_rasterizer_core
// 5x8 character generator: one drawable character in, forty colored pixels out.
// ----------------------------------------------------------------------------
// Each character word is taken while the glyph queue is not full. Codes 32
// to 126 are drawn as forty pixels, column 0 to 4 and row 0 to 7 within
// each column, one pixel per cycle while m_tready holds, so the rate of
// drawable characters is set by the single pixel walker in the back end.
// Other codes only move the cursor. A two-entry glyph queue lets up to two
// characters be taken ahead of the one being drawn. The cursor advances by
// 6 after every character; coordinates wrap at COORD_BITS.
// ----------------------------------------------------------------------------
module glyph_text_rasterizer_core #(
    parameter int COORD_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // start_x, pos_y, char_code, fg_color, bg_color
    input  logic        s_tuser,   // first_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // pixel_x, pixel_y, pixel_color
    output logic        m_tlast    // last_pixel
);
    import gtr_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t q_wdata;
    cmd_t q_rdata;

    gtr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    gtr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    gtr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: rtl/core/gtr_front.sv
// ----------------------------------------------------------------------------
// gtr_front
// Accepts characters, tracks the cursor and queues drawable glyphs.
// ----------------------------------------------------------------------------
module gtr_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [71:0]         s_tdata,   // start_x, pos_y, char_code, fg_color, bg_color
    input  logic                s_tuser,   // first_char
    input  logic                q_full,
    output logic                q_push,
    output gtr_pkg::cmd_t       q_wdata
);
    import gtr_pkg::*;

    logic [COORD_BITS-1:0] cursor_reg;
    logic [COORD_BITS-1:0] cursor_next;
    logic [COORD_BITS-1:0] cell_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [7:0]            char_code;
    logic [7:0]            code_ofs;
    logic                  accept;
    logic                  printable;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign char_code = s_tdata[39:32];
    assign pos_y     = s_tdata[16 +: COORD_BITS];
    assign cell_x    = s_tuser ? s_tdata[COORD_BITS-1:0] : cursor_reg;
    assign printable = (char_code >= CODE_LOW) && (char_code <= CODE_HIGH);
    assign code_ofs  = char_code - CODE_LOW;

    // Advance the cursor on every character, drawn or not
    assign cursor_next = accept ? cell_x + COORD_BITS'(CELL_STEP) : cursor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
        end
    end

    assign q_push         = accept && printable;
    assign q_wdata.cell_x = FIELD_BITS'(cell_x);
    assign q_wdata.pos_y  = FIELD_BITS'(pos_y);
    assign q_wdata.fg     = s_tdata[55:40];
    assign q_wdata.bg     = s_tdata[71:56];
    assign q_wdata.glyph  = glyph_cols(code_ofs[6:0]);

endmodule

FILE: rtl/core/gtr_queue.sv
// ----------------------------------------------------------------------------
// gtr_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module gtr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gtr_pkg::cmd_t wdata,
    input  logic          pop,
    output gtr_pkg::cmd_t rdata,
    output logic          full,
    output logic          empty
);
    import gtr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: rtl/core/gtr_back.sv
// ----------------------------------------------------------------------------
// gtr_back
// Walks one glyph column-major and streams its forty pixels.
// ----------------------------------------------------------------------------
module gtr_back #(
    parameter int COORD_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  gtr_pkg::cmd_t q_rdata,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [47:0]   m_tdata,   // pixel_x, pixel_y, pixel_color
    output logic          m_tlast    // last_pixel
);
    import gtr_pkg::*;

    cmd_t                  job_reg;
    cmd_t                  job_next;
    logic                  job_valid_reg;
    logic                  job_valid_next;
    logic [2:0]            col_reg;
    logic [2:0]            col_next;
    logic [2:0]            row_reg;
    logic [2:0]            row_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [FIELD_BITS-1:0] out_x_reg;
    logic [FIELD_BITS-1:0] out_x_next;
    logic [FIELD_BITS-1:0] out_y_reg;
    logic [FIELD_BITS-1:0] out_y_next;
    logic [FIELD_BITS-1:0] out_color_reg;
    logic [FIELD_BITS-1:0] out_color_next;
    logic                  out_last_reg;
    logic                  out_last_next;

    logic                  load_out;
    logic                  emit;
    logic                  at_last;
    logic                  job_done;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic                  bit_set;

    assign load_out = !out_valid_reg || m_tready;
    assign emit     = job_valid_reg && load_out;
    assign at_last  = (col_reg == LAST_COL) && (row_reg == LAST_ROW);
    assign job_done = emit && at_last;
    // Take the next glyph in the cycle the current one hands off its last pixel
    assign q_pop    = !q_empty && (!job_valid_reg || job_done);

    assign px      = job_reg.cell_x[COORD_BITS-1:0] + COORD_BITS'(col_reg);
    assign py      = job_reg.pos_y[COORD_BITS-1:0] + COORD_BITS'(row_reg);
    assign bit_set = job_reg.glyph[{col_reg, row_reg}];

    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        if (q_pop)
        begin
            job_next       = q_rdata;
            job_valid_next = 1'b1;
            col_next       = '0;
            row_next       = '0;
        end
        else if (emit)
        begin
            if (job_done)
            begin
                job_valid_next = 1'b0;
            end
            if (row_reg == LAST_ROW)
            begin
                row_next = '0;
                col_next = col_reg + 1'b1;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;
        if (load_out)
        begin
            out_valid_next = emit;
        end
        if (emit)
        begin
            out_x_next     = FIELD_BITS'(px);
            out_y_next     = FIELD_BITS'(py);
            out_color_next = bit_set ? job_reg.fg : job_reg.bg;
            out_last_next  = at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            out_valid_reg <= out_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_color_reg, out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: sim/glyph_text_rasterizer_core_test.sv
// ----------------------------------------------------------------------------
// glyph_text_rasterizer_core_test
// Self-checking bench for the 5x8 character generator.
// ----------------------------------------------------------------------------
// Character words go in on the slave stream with random gaps. A model of the
// font and the cursor builds the forty expected pixels of every printable
// character. The master stream is stalled at random, and every pixel word is
// checked against the oldest expected pixel.
// ----------------------------------------------------------------------------
module glyph_text_rasterizer_core_test;

    localparam logic [7:0]  FIRST_PRINTABLE = 8'd32;
    localparam logic [7:0]  LAST_PRINTABLE  = 8'd126;
    localparam logic [15:0] CURSOR_STEP     = 16'd6;
    localparam int          COLS_PER_GLYPH  = 5;
    localparam int          ROWS_PER_GLYPH  = 8;
    localparam int          SETTLE_CYCLES   = 60;

    // 95 glyphs, code 32 first; each entry is {col0, col1, col2, col3, col4}
    localparam logic [95*40-1:0] FONT_BITS = {
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h8080808080,
        40'h0003070000, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h1008081008
    };

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] color;
        logic        last;
    } pixel_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // start_x, pos_y, char_code, fg_color, bg_color
    logic        s_tuser;   // first_char
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // pixel_x, pixel_y, pixel_color
    logic        m_tlast;   // last_pixel

    pixel_t      pending_pixels[$];
    logic [15:0] model_cursor;
    int          errors;
    int          sent_chars;
    bit          no_gaps;

    glyph_text_rasterizer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] font_column(input logic [7:0] code, input int col);
        logic [39:0] glyph;
        glyph = FONT_BITS[40*(94 - (code - FIRST_PRINTABLE)) +: 40];
        return glyph[39 - 8*col -: 8];
    endfunction

    // Place the cell, move the cursor and queue the pixels of one character.
    task automatic rasterize_char(input bit first, input logic [15:0] start_x,
                                  input logic [15:0] pos_y, input logic [7:0] code,
                                  input logic [15:0] fg, input logic [15:0] bg);
        logic [15:0] cell_x;
        logic [7:0]  bits;
        pixel_t      px;
        cell_x       = first ? start_x : model_cursor;
        model_cursor = cell_x + CURSOR_STEP;
        if (code < FIRST_PRINTABLE || code > LAST_PRINTABLE)
            return;
        for (int col = 0; col < COLS_PER_GLYPH; col++)
        begin
            bits = font_column(code, col);
            for (int row = 0; row < ROWS_PER_GLYPH; row++)
            begin
                px.x     = cell_x + 16'(col);
                px.y     = pos_y + 16'(row);
                px.color = bits[row] ? fg : bg;
                px.last  = (col == COLS_PER_GLYPH - 1) && (row == ROWS_PER_GLYPH - 1);
                pending_pixels.push_back(px);
            end
        end
    endtask

    task automatic send_char(input bit first, input logic [15:0] start_x,
                             input logic [15:0] pos_y, input logic [7:0] code,
                             input logic [15:0] fg, input logic [15:0] bg);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        s_tuser  = first;
        s_tdata  = {bg, fg, code, pos_y, start_x};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        sent_chars++;
        rasterize_char(first, start_x, pos_y, code, fg, bg);
    endtask

    // Hold the input idle until every queued pixel has come out.
    task automatic drain_pixels();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_cursor_after_reset();
        // continue with no string started: cursor is zero
        send_char(1'b0, 16'h1234, 16'd0, "A", 16'hFFFF, 16'h0000);
        send_char(1'b0, 16'hFFFF, 16'd0, "B", 16'h0000, 16'hFFFF);
        send_char(1'b0, 16'h0000, 16'd0, "C", 16'hF800, 16'h07E0);
    endtask

    task automatic test_code_edges();
        send_char(1'b1, 16'd100, 16'd20, 8'd32, 16'hAAAA, 16'h5555);
        send_char(1'b0, 16'd0, 16'd20, 8'd126, 16'h5555, 16'hAAAA);
        send_char(1'b0, 16'd0, 16'd20, 8'd31, 16'h1111, 16'h2222);
        send_char(1'b0, 16'd0, 16'd20, 8'd127, 16'h1111, 16'h2222);
        send_char(1'b0, 16'd0, 16'd20, 8'd0, 16'h1111, 16'h2222);
        send_char(1'b0, 16'd0, 16'd20, 8'd255, 16'h1111, 16'h2222);
        // underscore uses the bottom glyph row
        send_char(1'b0, 16'd0, 16'd20, "_", 16'h001F, 16'hFFE0);
        send_char(1'b1, 16'd0, 16'd0, 8'd128, 16'h0, 16'h0);
        send_char(1'b0, 16'd0, 16'd0, "~", 16'h0F0F, 16'hF0F0);
    endtask

    task automatic test_coord_wrap();
        send_char(1'b1, 16'hFFFF, 16'hFFFF, "M", 16'hFFFF, 16'h0000);
        send_char(1'b0, 16'h0000, 16'hFFFC, "W", 16'h0000, 16'hFFFF);
        send_char(1'b1, 16'hFFFA, 16'hFFF9, "#", 16'h8001, 16'h7FFE);
        send_char(1'b0, 16'hFFFF, 16'hFFF9, "@", 16'h7FFE, 16'h8001);
        send_char(1'b0, 16'hFFFF, 16'h0000, 8'd10, 16'h0, 16'h0);
        send_char(1'b0, 16'hFFFF, 16'h0000, "z", 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_drain_between_chars();
        no_gaps = 1'b1;
        send_char(1'b1, 16'd300, 16'd40, "H", 16'hFFFF, 16'h0000);
        send_char(1'b0, 16'd0, 16'd40, "i", 16'hFFFF, 16'h0000);
        drain_pixels();
        send_char(1'b0, 16'd0, 16'd40, "!", 16'h0000, 16'hFFFF);
        no_gaps = 1'b0;
        drain_pixels();
    endtask

    // Mostly well formed strings; some junk codes and stray first flags.
    task automatic test_random_strings();
        int          len;
        bit          first;
        logic [15:0] sx;
        logic [15:0] py;
        logic [15:0] fg;
        logic [15:0] bg;
        logic [7:0]  code;
        sent_chars = 0;
        while (sent_chars < 208)
        begin
            no_gaps = ($urandom_range(0, 4) == 0);
            sx = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(65515, 65535))
                                             : 16'($urandom_range(0, 65535));
            py = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(65528, 65535))
                                             : 16'($urandom_range(0, 65535));
            fg = 16'($urandom_range(0, 65535));
            bg = 16'($urandom_range(0, 65535));
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                first = (i == 0);
                if ($urandom_range(0, 19) == 0)
                    first = !first;
                code = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(32, 126));
                if ($urandom_range(0, 5) == 0)
                begin
                    fg = 16'($urandom_range(0, 65535));
                    bg = 16'($urandom_range(0, 65535));
                end
                if ($urandom_range(0, 7) == 0)
                    py = 16'($urandom_range(0, 65535));
                send_char(first, first ? sx : 16'($urandom_range(0, 65535)),
                          py, code, fg, bg);
            end
            if ($urandom_range(0, 9) == 0)
                drain_pixels();
        end
        no_gaps = 1'b0;
    endtask

    // Stall the pixel stream at random before each word, unless no_gaps is set.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 4);
            @(negedge clk);
            repeat (stall)
            begin
                m_tready = 1'b0;
                @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        pixel_t want;
        pixel_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tlast};
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel x=%h y=%h color=%h last=%b",
                         $time, got.x, got.y, got.color, got.last);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got.x !== want.x)
                begin
                    errors++;
                    $display("%0t: pixel_x expected %h got %h", $time, want.x, got.x);
                end
                if (got.y !== want.y)
                begin
                    errors++;
                    $display("%0t: pixel_y expected %h got %h", $time, want.y, got.y);
                end
                if (got.color !== want.color)
                begin
                    errors++;
                    $display("%0t: pixel_color expected %h got %h",
                             $time, want.color, got.color);
                end
                if (got.last !== want.last)
                begin
                    errors++;
                    $display("%0t: last_pixel expected %b got %b",
                             $time, want.last, got.last);
                end
            end
        end
    end

    initial
    begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        model_cursor = '0;
        errors       = 0;
        sent_chars   = 0;
        no_gaps      = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_cursor_after_reset();
        test_code_edges();
        test_coord_wrap();
        test_drain_between_chars();
        test_random_strings();

        drain_pixels();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending_pixels.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/gtr_pkg.sv
rtl/core/gtr_front.sv
rtl/core/gtr_queue.sv
rtl/core/gtr_back.sv
rtl/core/glyph_text_rasterizer_core.sv
sim/glyph_text_rasterizer_core_test.sv
